// ===== hw/rtl/fibonacci_clock_pixel_encoder_core_defines.svh =====
// ----------------------------------------------------------------------------
// Fibonacci clock pixel encoder - assertion macros
// Shared concurrent assertion helpers for the checker.
// ----------------------------------------------------------------------------
`ifndef FIBONACCI_CLOCK_PIXEL_ENCODER_CORE_DEFINES_SVH
`define FIBONACCI_CLOCK_PIXEL_ENCODER_CORE_DEFINES_SVH

// checked only out of reset
`define FCPE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked during reset as well
`define FCPE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hw/rtl/fcpe_pkg.sv =====
// ----------------------------------------------------------------------------
// Fibonacci clock pixel encoder - package
// Types, register codes and the decomposition and color tables.
// ----------------------------------------------------------------------------
`default_nettype none

package fcpe_pkg;

  localparam int unsigned NumSquares = 5;
  localparam logic [3:0]  PixLast    = 4'd8;
  localparam logic [3:0]  NumThemes  = 4'd10;

  typedef enum logic {
    CFG_THEME   = 1'b0,
    CFG_DISPLAY = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [NumSquares-1:0] hmask;
    logic [NumSquares-1:0] mmask;
  } masks_t;

  typedef struct packed {
    logic [3:0] theme;
    logic       display_on;
  } cfg_t;

  // pick mod 3 by folding base-4 digits
  function automatic logic [1:0] mod3(input logic [7:0] p);
    logic [3:0] s;
    logic [2:0] f;
    logic [1:0] r;
    s = {2'b00, p[1:0]} + {2'b00, p[3:2]} + {2'b00, p[5:4]} + {2'b00, p[7:6]};
    f = {1'b0, s[1:0]} + {1'b0, s[3:2]};
    unique case (f)
      3'd0, 3'd3, 3'd6: r = 2'd0;
      3'd1, 3'd4:       r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

  // units 0..12 -> choice select from pick
  function automatic logic [1:0] choice_sel(input logic [3:0] units, input logic [7:0] pick);
    logic [1:0] sel;
    unique case (units)
      4'd0, 4'd12:                 sel = 2'd0;
      4'd1, 4'd2, 4'd9, 4'd10,
      4'd11:                       sel = {1'b0, pick[0]};
      4'd6:                        sel = pick[1:0];
      default:                     sel = mod3(pick);
    endcase
    return sel;
  endfunction

  function automatic logic [NumSquares-1:0] choice_mask(input logic [3:0] units,
                                                        input logic [1:0] sel);
    logic [NumSquares-1:0] m;
    unique case ({units, sel})
      {4'd1,  2'd0}: m = 5'h01;
      {4'd1,  2'd1}: m = 5'h02;
      {4'd2,  2'd0}: m = 5'h04;
      {4'd2,  2'd1}: m = 5'h03;
      {4'd3,  2'd0}: m = 5'h08;
      {4'd3,  2'd1}: m = 5'h05;
      {4'd3,  2'd2}: m = 5'h06;
      {4'd4,  2'd0}: m = 5'h09;
      {4'd4,  2'd1}: m = 5'h0A;
      {4'd4,  2'd2}: m = 5'h07;
      {4'd5,  2'd0}: m = 5'h10;
      {4'd5,  2'd1}: m = 5'h0C;
      {4'd5,  2'd2}: m = 5'h0B;
      {4'd6,  2'd0}: m = 5'h11;
      {4'd6,  2'd1}: m = 5'h12;
      {4'd6,  2'd2}: m = 5'h0D;
      {4'd6,  2'd3}: m = 5'h0E;
      {4'd7,  2'd0}: m = 5'h14;
      {4'd7,  2'd1}: m = 5'h13;
      {4'd7,  2'd2}: m = 5'h0F;
      {4'd8,  2'd0}: m = 5'h18;
      {4'd8,  2'd1}: m = 5'h15;
      {4'd8,  2'd2}: m = 5'h16;
      {4'd9,  2'd0}: m = 5'h19;
      {4'd9,  2'd1}: m = 5'h1A;
      {4'd10, 2'd0}: m = 5'h1C;
      {4'd10, 2'd1}: m = 5'h1B;
      {4'd11, 2'd0}: m = 5'h1D;
      {4'd11, 2'd1}: m = 5'h1E;
      {4'd12, 2'd0}: m = 5'h1F;
      default:       m = 5'h00;
    endcase
    return m;
  endfunction

  // code: 1 hour, 2 minute, 3 both, 0 black
  function automatic logic [23:0] theme_color(input logic [3:0] t, input logic [1:0] code);
    logic [23:0] h, m, b, c;
    unique case (t)
      4'd1:    begin h = 24'hFF0A0A; m = 24'hF8DE00; b = 24'h0A0AFF; end
      4'd2:    begin h = 24'h502800; m = 24'h14C814; b = 24'hFF640A; end
      4'd3:    begin h = 24'hF564C9; m = 24'h72F736; b = 24'h71EBDC; end
      4'd4:    begin h = 24'hFF7B7B; m = 24'h8FFF70; b = 24'h7878FF; end
      4'd5:    begin h = 24'hD4312D; m = 24'h91D231; b = 24'h8D5FE0; end
      4'd6:    begin h = 24'hD13EC8; m = 24'h45E8E0; b = 24'h5046CA; end
      4'd7:    begin h = 24'hED1414; m = 24'hF6F336; b = 24'hFF7E15; end
      4'd8:    begin h = 24'h462300; m = 24'h467A0A; b = 24'hC8B600; end
      4'd9:    begin h = 24'hD32222; m = 24'h50974E; b = 24'h101895; end
      default: begin h = 24'hFF0A0A; m = 24'h0AFF0A; b = 24'h0A0AFF; end
    endcase
    unique case (code)
      2'd1:    c = h;
      2'd2:    c = m;
      2'd3:    c = b;
      default: c = 24'h000000;
    endcase
    return c;
  endfunction

  function automatic logic [2:0] pixel_square(input logic [3:0] pix);
    logic [2:0] sq;
    unique case (pix)
      4'd0:       sq = 3'd0;
      4'd1:       sq = 3'd1;
      4'd2:       sq = 3'd2;
      4'd3, 4'd4: sq = 3'd3;
      default:    sq = 3'd4;
    endcase
    return sq;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/fcpe_front.sv =====
// ----------------------------------------------------------------------------
// Fibonacci clock pixel encoder - front end
// Accepts time requests and resolves the hour and minute square masks.
// ----------------------------------------------------------------------------
`default_nettype none

module fcpe_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [4:0]       hour_i,
  input  logic [5:0]       minute_i,
  input  logic [7:0]       hour_pick_i,
  input  logic [7:0]       minute_pick_i,
  output logic             push_o,
  output fcpe_pkg::masks_t push_entry_o,
  input  logic             full_i
);
  import fcpe_pkg::*;

  logic        valid_q, valid_d;
  masks_t      entry_q;
  masks_t      entry_d;
  logic        accept;
  logic [4:0]  hour_red;
  logic [13:0] min_prod;
  logic [3:0]  min_units;

  assign in_stall_o = valid_q & full_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign push_o     = valid_q & ~full_i;

  always_comb begin
    hour_red = (hour_i >= 5'd13) ? hour_i - 5'd12 : hour_i;
    min_prod = {8'd0, minute_i} * 14'd205;
    min_units = min_prod[13:10];
    if (hour_red > 5'd12) begin
      entry_d.hmask = '0;
    end else begin
      entry_d.hmask = choice_mask(hour_red[3:0], choice_sel(hour_red[3:0], hour_pick_i));
    end
    entry_d.mmask = choice_mask(min_units, choice_sel(min_units, minute_pick_i));
  end

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      entry_q <= entry_d;
    end
  end

  assign push_entry_o = entry_q;

endmodule

`default_nettype wire

// ===== hw/rtl/fcpe_queue.sv =====
// ----------------------------------------------------------------------------
// Fibonacci clock pixel encoder - mask queue
// Two-entry FIFO decoupling the front end from the pixel sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module fcpe_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  fcpe_pkg::masks_t entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output fcpe_pkg::masks_t head_o,
  output logic             empty_o
);
  import fcpe_pkg::*;

  masks_t     mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o  = count_q == 2'd2;
  assign empty_o = count_q == 2'd0;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fcpe_back.sv =====
// ----------------------------------------------------------------------------
// Fibonacci clock pixel encoder - pixel sequencer
// Walks the nine pixels of the head entry and drives the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fcpe_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  fcpe_pkg::masks_t head_i,
  input  logic             empty_i,
  output logic             pop_o,
  input  fcpe_pkg::cfg_t   cfg_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [3:0]       pixel_index_o,
  output logic [7:0]       red_o,
  output logic [7:0]       green_o,
  output logic [7:0]       blue_o,
  output logic             last_o
);
  import fcpe_pkg::*;

  logic        valid_q, valid_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [3:0]  pix_q;
  logic [23:0] rgb_q;
  logic        last_q;
  logic        adv;
  logic        load;
  logic [2:0]  sq;
  logic [1:0]  code;
  logic [23:0] rgb_d;

  assign adv   = ~valid_q | ~out_stall_i;
  assign load  = adv & ~empty_i;
  assign pop_o = load & (cnt_q == PixLast);

  always_comb begin
    sq    = pixel_square(cnt_q);
    code  = {head_i.mmask[sq], head_i.hmask[sq]};
    rgb_d = cfg_i.display_on ? theme_color(cfg_i.theme, code) : 24'h000000;
  end

  always_comb begin
    valid_d = valid_q;
    cnt_d   = cnt_q;
    if (adv) begin
      valid_d = ~empty_i;
    end
    if (load) begin
      cnt_d = (cnt_q == PixLast) ? 4'd0 : cnt_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= 4'd0;
    end else begin
      valid_q <= valid_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      pix_q  <= cnt_q;
      rgb_q  <= rgb_d;
      last_q <= cnt_q == PixLast;
    end
  end

  assign out_valid_o   = valid_q;
  assign pixel_index_o = pix_q;
  assign red_o         = rgb_q[23:16];
  assign green_o       = rgb_q[15:8];
  assign blue_o        = rgb_q[7:0];
  assign last_o        = last_q;

endmodule

`default_nettype wire

// ===== hw/rtl/fibonacci_clock_pixel_encoder_core.sv =====
// ----------------------------------------------------------------------------
// Fibonacci clock pixel encoder - top level
// Turns a time request into nine themed RGB pixels for an LED chain.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+-------------------------------------------
//  in      | in_valid_i/in_stall_o | hour_i minute_i hour_pick_i minute_pick_i
//  out     | out_valid_o/out_stall_i | pixel_index_o red_o green_o blue_o last_o
//  cfg     | cfg_we_i              | cfg_idx_i cfg_data_i
//
//  Each request yields nine pixels, one per cycle from the pixel sequencer
//  while out_stall_i is low; requests pass front end, queue, output register.
//  The front end and a two-entry mask queue absorb requests while the
//  sequencer works, so input is stalled only when both are full.
//  Output stall freezes the output register and the sequencer.
//  Reset needs no clearing pass; config resets to theme 0, display on.
// ----------------------------------------------------------------------------
`default_nettype none

module fibonacci_clock_pixel_encoder_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  fcpe_pkg::cfg_idx_e   cfg_idx_i,
  input  logic [3:0]           cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [4:0]           hour_i,
  input  logic [5:0]           minute_i,
  input  logic [7:0]           hour_pick_i,
  input  logic [7:0]           minute_pick_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [3:0]           pixel_index_o,
  output logic [7:0]           red_o,
  output logic [7:0]           green_o,
  output logic [7:0]           blue_o,
  output logic                 last_o
);
  import fcpe_pkg::*;

  cfg_t   cfg_q, cfg_d;
  logic   push;
  logic   full;
  logic   pop;
  logic   empty;
  masks_t push_entry;
  masks_t head;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_THEME: begin
          if (cfg_data_i < NumThemes) begin
            cfg_d.theme = cfg_data_i;
          end
        end
        CFG_DISPLAY: cfg_d.display_on = cfg_data_i[0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{theme: 4'd0, display_on: 1'b1};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  fcpe_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .hour_i,
    .minute_i,
    .hour_pick_i,
    .minute_pick_i,
    .push_o       (push),
    .push_entry_o (push_entry),
    .full_i       (full)
  );

  fcpe_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (empty)
  );

  fcpe_back u_back (
    .clk_i,
    .rst_ni,
    .head_i  (head),
    .empty_i (empty),
    .pop_o   (pop),
    .cfg_i   (cfg_q),
    .out_valid_o,
    .out_stall_i,
    .pixel_index_o,
    .red_o,
    .green_o,
    .blue_o,
    .last_o
  );

endmodule

`default_nettype wire

// ===== hw/rtl/fcpe_checker.sv =====
// ----------------------------------------------------------------------------
// Fibonacci clock pixel encoder - port checker
// Watches the output channel for frame ordering and handshake rules.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fibonacci_clock_pixel_encoder_core_defines.svh"

module fcpe_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [3:0] pixel_index_o,
  input logic [7:0] red_o,
  input logic [7:0] green_o,
  input logic [7:0] blue_o,
  input logic       last_o
);
  import fcpe_pkg::*;

  `FCPE_ASSERT(a_hold_valid, out_valid_o && out_stall_i |=> out_valid_o, "valid dropped")
  `FCPE_ASSERT(a_hold_data, out_valid_o && out_stall_i |=> $stable(pixel_index_o) && $stable(red_o) && $stable(green_o) && $stable(blue_o) && $stable(last_o), "stalled pixel changed")
  `FCPE_ASSERT(a_frame_seq, out_valid_o && !out_stall_i && !last_o |=> out_valid_o && (pixel_index_o == $past(pixel_index_o) + 4'd1), "frame not contiguous")
  `FCPE_ASSERT(a_last_pos, out_valid_o |-> (last_o == (pixel_index_o == PixLast)), "last misplaced")
  `FCPE_ASSERT_ALWAYS(a_rst_idle, !rst_ni |-> !out_valid_o, "valid in reset")

endmodule

bind fibonacci_clock_pixel_encoder_core fcpe_checker u_fcpe_checker (
  .clk_i,
  .rst_ni,
  .out_valid_o,
  .out_stall_i,
  .pixel_index_o,
  .red_o,
  .green_o,
  .blue_o,
  .last_o
);

`default_nettype wire
